// ===== design/zbh_pkg.sv =====
// Shared constants, codes and payload types of the Zobrist board hasher.
// No dependencies; every design file imports this package.
`timescale 1ns / 1ps

package zbh_pkg;

  // Board and wall limits that size the key memories.
  localparam int MAX_BOARD = 16;
  localparam int MAX_WALLS = 15;

  localparam int CELLS   = MAX_BOARD * MAX_BOARD;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int ROW_W   = $clog2(MAX_BOARD + 1);
  localparam int WALL_AW = (MAX_WALLS > 0) ? $clog2(MAX_WALLS + 1) : 1;
  localparam int WALLS   = MAX_WALLS + 1;

  // Generator and key packing.
  localparam logic [31:0] SEED          = 32'd1804289383;
  localparam int          DRAWS_PER_KEY = 4;
  localparam int          DRAW_W        = $clog2(DRAWS_PER_KEY);

  // Cell counter saturates at its all-ones value.
  localparam int           CNT_W   = 9;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_SIZE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WALLS = 4'd1;

  localparam logic [4:0] BOARD_SIZE_RST    = 5'd9;
  localparam logic [3:0] INITIAL_WALLS_RST = 4'd10;

  // Key kinds in draw order: per cell, then per wall count.
  localparam logic [1:0] KIND_H  = 2'd0;
  localparam logic [1:0] KIND_V  = 2'd1;
  localparam logic [1:0] KIND_WP = 2'd2;
  localparam logic [1:0] KIND_BP = 2'd3;
  localparam logic [1:0] KIND_WW = 2'd0;
  localparam logic [1:0] KIND_BW = 2'd1;

  typedef enum logic [1:0] {
    ST_FILL_CELLS,
    ST_FILL_WALLS,
    ST_RUN
  } zbh_state_e;

  typedef struct packed {
    logic [3:0] white_row;
    logic [3:0] white_col;
    logic [3:0] black_row;
    logic [3:0] black_col;
    logic [3:0] white_walls_left;
    logic [3:0] black_walls_left;
    logic       cell_is_horizontal;
    logic       last;
  } zbh_in_t;

  typedef struct packed {
    logic [63:0] position_hash;
    logic        index_error;
  } zbh_out_t;

endpackage

// ===== design/zobrist_board_hash_top.sv =====
// Top level of the Zobrist board hasher: key generator, key memories and hash stage.
// Depends on zbh_pkg for limits, codes and payload structs.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one board cell per
//   transfer, row-major. The first cell of a board also carries pawn positions and
//   wall counts; the cell flagged last closes the board.
//   Output channel (out_valid_o / out_ready_i / out_data_o) carries one hash and an
//   error flag per board, registered in the hash stage and then in the output register.
//   Throughput is one cell per cycle while in_ready_o is high; each cell costs one read
//   of the horizontal and vertical key memories, registered, and one 64-bit XOR into
//   the accumulator. Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take
//   effect at once; indexes 0 and 1 restart the key fill, others are ignored.
//   After reset and after each accepted register write the block reseeds its
//   generator and fills the key memories, one 16-bit draw per cycle, sized by the board
//   size and the wall count in use. in_ready_o stays low during the fill.
//   When the receiver stalls, the finished hash holds in the output register; cells
//   keep flowing until a second last cell reaches the hash stage, which then holds
//   and drops in_ready_o until the output register frees.
module zobrist_board_hash_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [zbh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [zbh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  zbh_pkg::zbh_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output zbh_pkg::zbh_out_t            out_data_o
);
  import zbh_pkg::*;

  localparam logic [DRAW_W-1:0] DRAW_LAST = DRAW_W'(DRAWS_PER_KEY - 1);

  // Configuration and effective sizes.
  logic [4:0]         board_size_q;
  logic [3:0]         walls_q;
  logic [ROW_W-1:0]   eff_n;
  logic [WALL_AW-1:0] eff_w;
  logic [2*ROW_W-1:0] nn;
  logic               cfg_hit;

  // Fill sequencer.
  zbh_state_e         state_q, state_d;
  logic [31:0]        prng_q, prng_d, draw;
  logic [63:0]        key_q, key_d, key_word;
  logic [DRAW_W-1:0]  draw_q, draw_d;
  logic [1:0]         kind_q, kind_d;
  logic [ROW_W-1:0]   row_q, row_d, col_q, col_d;
  logic [WALL_AW-1:0] wall_q, wall_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               fill_active, key_wr, cell_phase, wall_phase;
  logic               last_col, last_row;

  // Memory ports.
  logic [CELL_AW-1:0] cell_addr, wp_addr, bp_addr;
  logic [WALL_AW-1:0] ww_addr, bw_addr;
  logic               h_we, v_we, wp_we, bp_we, ww_we, bw_we;
  logic [63:0]        h_mem  [CELLS];
  logic [63:0]        v_mem  [CELLS];
  logic [63:0]        wp_mem [CELLS];
  logic [63:0]        bp_mem [CELLS];
  logic [63:0]        ww_mem [WALLS];
  logic [63:0]        bw_mem [WALLS];
  logic [63:0]        h_rd_q, v_rd_q, wp_rd_q, bp_rd_q, ww_rd_q, bw_rd_q;

  // Hash stage.
  logic        in_fire, s1_fire, run_ready;
  logic        cell_ok, wp_ok, bp_ok, ww_ok, bw_ok;
  logic        s1_valid_q, s1_first_q, s1_horiz_q, s1_last_q;
  logic        s1_cell_ok_q, s1_wp_ok_q, s1_bp_ok_q, s1_ww_ok_q, s1_bw_ok_q;
  logic [63:0] acc_q, acc_new;
  logic        err_q, err_new;
  logic        out_valid_q;
  zbh_out_t    out_q;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  // Clamp the registers to the sizes the memories hold.
  always_comb begin
    if (board_size_q == 5'd0) begin
      eff_n = ROW_W'(1);
    end else if (board_size_q > MAX_BOARD) begin
      eff_n = ROW_W'(MAX_BOARD);
    end else begin
      eff_n = ROW_W'(board_size_q);
    end
    if (walls_q > MAX_WALLS) begin
      eff_w = WALL_AW'(MAX_WALLS);
    end else begin
      eff_w = WALL_AW'(walls_q);
    end
  end

  assign nn      = {{ROW_W{1'b0}}, eff_n} * {{ROW_W{1'b0}}, eff_n};
  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_BOARD_SIZE || cfg_idx_i == CFG_INITIAL_WALLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_size_q <= BOARD_SIZE_RST;
      walls_q      <= INITIAL_WALLS_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_BOARD_SIZE) begin
        board_size_q <= cfg_data_i[4:0];
      end
      if (cfg_idx_i == CFG_INITIAL_WALLS) begin
        walls_q <= cfg_data_i[3:0];
      end
    end
  end

  // Generator: one draw per fill cycle; each key collects four low halves, first lowest.
  assign draw     = xorshift32(prng_q);
  assign key_word = {draw[15:0], key_q[63:16]};
  assign last_col = (col_q == eff_n - ROW_W'(1));
  assign last_row = (row_q == eff_n - ROW_W'(1));

  // Next state of the fill sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL_CELLS: begin
        if (key_wr && kind_q == KIND_BP && last_col && last_row) begin
          state_d = ST_FILL_WALLS;
        end
      end
      ST_FILL_WALLS: begin
        if (key_wr && kind_q == KIND_BW && wall_q == eff_w) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_FILL_CELLS;
      end
    endcase
    if (cfg_hit) begin
      state_d = ST_FILL_CELLS;
    end
  end

  // Sequencer outputs.
  always_comb begin
    fill_active = 1'b0;
    cell_phase  = 1'b0;
    wall_phase  = 1'b0;
    run_ready   = 1'b0;
    unique case (state_q)
      ST_FILL_CELLS: begin
        fill_active = 1'b1;
        cell_phase  = 1'b1;
      end
      ST_FILL_WALLS: begin
        fill_active = 1'b1;
        wall_phase  = 1'b1;
      end
      ST_RUN: begin
        run_ready = 1'b1;
      end
      default: begin
        fill_active = 1'b0;
      end
    endcase
  end

  assign key_wr = fill_active && (draw_q == DRAW_LAST);
  assign h_we   = key_wr && cell_phase && (kind_q == KIND_H);
  assign v_we   = key_wr && cell_phase && (kind_q == KIND_V);
  assign wp_we  = key_wr && cell_phase && (kind_q == KIND_WP);
  assign bp_we  = key_wr && cell_phase && (kind_q == KIND_BP);
  assign ww_we  = key_wr && wall_phase && (kind_q == KIND_WW);
  assign bw_we  = key_wr && wall_phase && (kind_q == KIND_BW);

  // Row and column counters walk the fill and then the streamed board.
  assign cell_addr = CELL_AW'(row_q * MAX_BOARD + col_q);
  assign wp_addr   = CELL_AW'(in_data_i.white_row * MAX_BOARD + in_data_i.white_col);
  assign bp_addr   = CELL_AW'(in_data_i.black_row * MAX_BOARD + in_data_i.black_col);
  assign ww_addr   = WALL_AW'(in_data_i.white_walls_left);
  assign bw_addr   = WALL_AW'(in_data_i.black_walls_left);

  assign cell_ok = ({1'b0, cnt_q} < nn);
  assign wp_ok   = (ROW_W'(in_data_i.white_row) < eff_n) &&
                   (ROW_W'(in_data_i.white_col) < eff_n);
  assign bp_ok   = (ROW_W'(in_data_i.black_row) < eff_n) &&
                   (ROW_W'(in_data_i.black_col) < eff_n);
  assign ww_ok   = (in_data_i.white_walls_left <= eff_w);
  assign bw_ok   = (in_data_i.black_walls_left <= eff_w);

  // The hash stage holds only when it carries a last cell and the output is full.
  assign s1_fire    = s1_valid_q && !(s1_last_q && out_valid_q && !out_ready_i);
  assign in_ready_o = run_ready && (!s1_valid_q || s1_fire);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    prng_d = prng_q;
    key_d  = key_q;
    draw_d = draw_q;
    kind_d = kind_q;
    row_d  = row_q;
    col_d  = col_q;
    wall_d = wall_q;
    cnt_d  = cnt_q;
    if (fill_active) begin
      prng_d = draw;
      key_d  = key_word;
      draw_d = draw_q + DRAW_W'(1);
    end
    if (key_wr && cell_phase) begin
      kind_d = kind_q + 2'd1;
      if (kind_q == KIND_BP) begin
        if (last_col) begin
          col_d = '0;
          row_d = last_row ? '0 : row_q + ROW_W'(1);
        end else begin
          col_d = col_q + ROW_W'(1);
        end
      end
    end
    if (key_wr && wall_phase) begin
      kind_d = (kind_q == KIND_BW) ? KIND_WW : KIND_BW;
      if (kind_q == KIND_BW) begin
        wall_d = wall_q + WALL_AW'(1);
      end
    end
    if (in_fire) begin
      if (in_data_i.last) begin
        cnt_d = '0;
        row_d = '0;
        col_d = '0;
      end else begin
        if (cnt_q != CNT_MAX) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (cell_ok) begin
          if (last_col) begin
            col_d = '0;
            row_d = row_q + ROW_W'(1);
          end else begin
            col_d = col_q + ROW_W'(1);
          end
        end
      end
    end
    // Restart the fill from the seed; any board in progress is abandoned.
    if (cfg_hit) begin
      prng_d = SEED;
      draw_d = '0;
      kind_d = KIND_H;
      row_d  = '0;
      col_d  = '0;
      wall_d = '0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL_CELLS;
      prng_q  <= SEED;
      draw_q  <= '0;
      kind_q  <= KIND_H;
      row_q   <= '0;
      col_q   <= '0;
      wall_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      prng_q  <= prng_d;
      draw_q  <= draw_d;
      kind_q  <= kind_d;
      row_q   <= row_d;
      col_q   <= col_d;
      wall_q  <= wall_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // Key memories: written by the fill, read once per transfer with registered data.
  always_ff @(posedge clk_i) begin
    if (h_we) begin
      h_mem[cell_addr] <= key_word;
    end
    if (v_we) begin
      v_mem[cell_addr] <= key_word;
    end
    if (in_fire) begin
      h_rd_q <= h_mem[cell_addr];
      v_rd_q <= v_mem[cell_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wp_we) begin
      wp_mem[cell_addr] <= key_word;
    end
    if (in_fire) begin
      wp_rd_q <= wp_mem[wp_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bp_we) begin
      bp_mem[cell_addr] <= key_word;
    end
    if (in_fire) begin
      bp_rd_q <= bp_mem[bp_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ww_we) begin
      ww_mem[wall_q] <= key_word;
    end
    if (in_fire) begin
      ww_rd_q <= ww_mem[ww_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bw_we) begin
      bw_mem[wall_q] <= key_word;
    end
    if (in_fire) begin
      bw_rd_q <= bw_mem[bw_addr];
    end
  end

  // Hash stage: fold the keys read for one cell into the accumulator.
  always_comb begin
    acc_new = s1_first_q ? 64'd0 : acc_q;
    err_new = s1_first_q ? 1'b0 : err_q;
    if (s1_cell_ok_q) begin
      acc_new = acc_new ^ (s1_horiz_q ? h_rd_q : v_rd_q);
    end else begin
      err_new = 1'b1;
    end
    if (s1_first_q) begin
      acc_new = acc_new ^ (s1_wp_ok_q ? wp_rd_q : 64'd0)
                        ^ (s1_bp_ok_q ? bp_rd_q : 64'd0)
                        ^ (s1_ww_ok_q ? ww_rd_q : 64'd0)
                        ^ (s1_bw_ok_q ? bw_rd_q : 64'd0);
      if (!s1_wp_ok_q || !s1_bp_ok_q || !s1_ww_ok_q || !s1_bw_ok_q) begin
        err_new = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_first_q   <= (cnt_q == '0);
      s1_horiz_q   <= in_data_i.cell_is_horizontal;
      s1_last_q    <= in_data_i.last;
      s1_cell_ok_q <= cell_ok;
      s1_wp_ok_q   <= wp_ok;
      s1_bp_ok_q   <= bp_ok;
      s1_ww_ok_q   <= ww_ok;
      s1_bw_ok_q   <= bw_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      err_q <= 1'b0;
    end else if (cfg_hit) begin
      acc_q <= '0;
      err_q <= 1'b0;
    end else if (s1_fire) begin
      acc_q <= acc_new;
      err_q <= err_new;
    end
  end

  // Output register: load a finished hash, hold it until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !out_ready_i) || (s1_fire && s1_last_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_q.position_hash <= acc_new;
      out_q.index_error   <= err_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/tb_zobrist_board_hash_top.sv =====
// Self-checking testbench for zobrist_board_hash_top: streams boards through the
// valid/ready input channel and checks every hash against a built-in predictor.
// Depends on zbh_pkg and the design sources only.
`timescale 1ns / 1ps

module tb_zobrist_board_hash_top;
  import zbh_pkg::*;

  // Cycles with no transfer and no register write before the run is declared hung.
  // The longest quiet stretch is a full key fill at 16x16 with 15 walls.
  localparam int QUIET_LIMIT  = 20000;
  localparam int RANDOM_CELLS = 60;
  localparam int SETTLE_WAIT  = 4;
  localparam int SHOWN_ERRORS = 10;
  localparam int IN_W         = $bits(zbh_in_t);

  // Block ports; every input starts at a known value.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  zbh_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  zbh_out_t              out_data_o;

  zobrist_board_hash_top dut (.*);

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: its own copy of the registers, the generator and the key tables.
  // ---------------------------------------------------------------------------
  logic [4:0]  board_reg;
  logic [3:0]  walls_reg;
  logic [31:0] gen_state;
  logic [63:0] horiz_key [CELLS];
  logic [63:0] vert_key  [CELLS];
  logic [63:0] wpawn_key [CELLS];
  logic [63:0] bpawn_key [CELLS];
  logic [63:0] wwall_key [WALLS];
  logic [63:0] bwall_key [WALLS];
  logic [63:0] hash_acc;
  int unsigned cell_cnt;
  logic        error_flag;

  zbh_out_t    expected_hashes[$];
  int unsigned cells_sent;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          no_idle;

  // Board edge in use: zero acts as one, anything past the maximum is clamped.
  function automatic int unsigned board_dim();
    if (board_reg == 0) return 1;
    if (board_reg > MAX_BOARD) return MAX_BOARD;
    return board_reg;
  endfunction

  function automatic int unsigned wall_top();
    return (walls_reg > MAX_WALLS) ? MAX_WALLS : walls_reg;
  endfunction

  // One xorshift step (13 left, 17 right, 5 left); keep the low half.
  function automatic logic [15:0] draw16();
    gen_state = gen_state ^ (gen_state << 13);
    gen_state = gen_state ^ (gen_state >> 17);
    gen_state = gen_state ^ (gen_state << 5);
    return gen_state[15:0];
  endfunction

  // Four draws, least significant first.
  function automatic logic [63:0] draw_key();
    logic [15:0] a, b, c, d;
    a = draw16();
    b = draw16();
    c = draw16();
    d = draw16();
    return {d, c, b, a};
  endfunction

  // Reseed and refill: per cell row-major (H, V, white pawn, black pawn),
  // then per wall count (white, black). Drops any board in progress.
  function automatic void fill_key_tables();
    int unsigned n, w, k;
    n = board_dim();
    w = wall_top();
    gen_state = SEED;
    for (int unsigned r = 0; r < n; r++) begin
      for (int unsigned col = 0; col < n; col++) begin
        k = r * MAX_BOARD + col;
        horiz_key[k] = draw_key();
        vert_key[k]  = draw_key();
        wpawn_key[k] = draw_key();
        bpawn_key[k] = draw_key();
      end
    end
    for (int unsigned i = 0; i <= w; i++) begin
      wwall_key[i] = draw_key();
      bwall_key[i] = draw_key();
    end
    hash_acc   = '0;
    cell_cnt   = 0;
    error_flag = 1'b0;
  endfunction

  // Register write as the block sees it; stray indexes leave everything alone.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_BOARD_SIZE) board_reg = val[4:0];
    else if (idx == CFG_INITIAL_WALLS) walls_reg = val[3:0];
    else return;
    fill_key_tables();
  endfunction

  // Fold one accepted cell into the running hash; queue the hash on the last cell.
  function automatic void fold_cell(input zbh_in_t c);
    int unsigned n, w, k;
    zbh_out_t    res;
    n = board_dim();
    w = wall_top();
    if (cell_cnt == 0) begin
      hash_acc   = '0;
      error_flag = 1'b0;
      if (c.white_row < n && c.white_col < n)
        hash_acc ^= wpawn_key[c.white_row * MAX_BOARD + c.white_col];
      else
        error_flag = 1'b1;
      if (c.black_row < n && c.black_col < n)
        hash_acc ^= bpawn_key[c.black_row * MAX_BOARD + c.black_col];
      else
        error_flag = 1'b1;
      if (c.white_walls_left <= w) hash_acc ^= wwall_key[c.white_walls_left];
      else error_flag = 1'b1;
      // Black's wall key follows black's own count.
      if (c.black_walls_left <= w) hash_acc ^= bwall_key[c.black_walls_left];
      else error_flag = 1'b1;
    end
    if (cell_cnt < n * n) begin
      k = (cell_cnt / n) * MAX_BOARD + (cell_cnt % n);
      hash_acc ^= c.cell_is_horizontal ? horiz_key[k] : vert_key[k];
    end else begin
      // Cell past the end of the board: nothing folded, flag it.
      error_flag = 1'b1;
    end
    if (cell_cnt < CNT_MAX) cell_cnt++;
    if (c.last) begin
      res.position_hash = hash_acc;
      res.index_error   = error_flag;
      expected_hashes.push_back(res);
      cell_cnt = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall per result, then check each transfer in order.
  // ---------------------------------------------------------------------------
  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) $display("%t: %s", $realtime, msg);
  endfunction

  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : hash_check
    zbh_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_hashes.size() == 0) begin
        flag_error($sformatf("unexpected result hash=%h err=%b",
                             out_data_o.position_hash, out_data_o.index_error));
      end else begin
        want = expected_hashes.pop_front();
        if (out_data_o.position_hash !== want.position_hash)
          flag_error($sformatf("position_hash: expected %h, got %h",
                               want.position_hash, out_data_o.position_hash));
        if (out_data_o.index_error !== want.index_error)
          flag_error($sformatf("index_error: expected %b, got %b",
                               want.index_error, out_data_o.index_error));
      end
    end
  end

  // Hang detector: count cycles with no transfer on either channel and no register write.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** zobrist_board_hash_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Present one cell after a random gap and hold it until the transfer.
  task automatic send_cell(input zbh_in_t c);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    fold_cell(c);
    cells_sent++;
  endtask

  // Random cell; a clean one keeps pawns on the board and wall counts in range.
  function automatic zbh_in_t rand_cell(input bit clean);
    zbh_in_t     c;
    int unsigned n, w;
    n = board_dim();
    w = wall_top();
    c = IN_W'($urandom);
    if (clean) begin
      c.white_row        = 4'($urandom_range(0, n - 1));
      c.white_col        = 4'($urandom_range(0, n - 1));
      c.black_row        = 4'($urandom_range(0, n - 1));
      c.black_col        = 4'($urandom_range(0, n - 1));
      c.white_walls_left = 4'($urandom_range(0, w));
      c.black_walls_left = 4'($urandom_range(0, w));
    end
    return c;
  endfunction

  // Stream a run of cells; close it with last on the final cell if asked.
  task automatic send_board(input int unsigned cells, input bit clean, input bit close);
    zbh_in_t c;
    for (int unsigned i = 0; i < cells; i++) begin
      c      = rand_cell(clean && i == 0);
      c.last = close && (i == cells - 1);
      send_cell(c);
    end
  endtask

  // Drop valid, drain every outstanding hash, then give the pipeline time to empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  // Register write on an idle block; hold off until the key fill is done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    apply_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic logic [CFG_IDX_W-1:0] stray_index();
    return CFG_IDX_W'($urandom_range(CFG_INITIAL_WALLS + 1, (1 << CFG_IDX_W) - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset configuration (9x9, 10 walls): all-zero and all-ones cells, a short board.
  task automatic test_reset_config();
    zbh_in_t c;
    c      = '0;
    c.last = 1'b1;
    send_cell(c);
    c = '1;            // pawns off the board, both wall counts too high
    send_cell(c);
    send_board(3, 1'b1, 1'b1);
  endtask

  // Smallest and largest boards, clamped register values, each range violation alone.
  task automatic test_size_extremes();
    zbh_in_t c;
    write_reg(CFG_BOARD_SIZE, 5'd1);
    write_reg(CFG_INITIAL_WALLS, 5'd0);
    send_board(1, 1'b1, 1'b1);
    send_board(3, 1'b1, 1'b1);   // cells past the single-cell board
    c                  = '0;
    c.white_walls_left = 4'd1;   // white count above the limit
    c.last             = 1'b1;
    send_cell(c);
    c                  = '0;
    c.black_walls_left = 4'd1;   // black count above the limit
    c.last             = 1'b1;
    send_cell(c);
    write_reg(CFG_BOARD_SIZE, 5'd0);
    send_board(1, 1'b1, 1'b1);
    write_reg(CFG_BOARD_SIZE, 5'd2);
    c           = '0;
    c.white_row = 4'd1;
    c.white_col = 4'd1;
    c.black_row = 4'd2;          // black just off the board
    c.last      = 1'b1;
    send_cell(c);
    send_board(4, 1'b1, 1'b1);
    write_reg(CFG_BOARD_SIZE, 5'd16);
    write_reg(CFG_INITIAL_WALLS, 5'h1f);   // upper bit dropped: 15 walls
    c = '1;                                // far corner, full wall counts
    send_cell(c);
    c                  = '1;
    c.white_walls_left = 4'd3;
    c.black_walls_left = 4'd12;
    send_cell(c);
    write_reg(CFG_BOARD_SIZE, 5'd31);      // clamps to the maximum board
    c = '1;
    send_cell(c);
  endtask

  // A write to a real register drops the board in progress; a stray index does not.
  task automatic test_board_abandon();
    write_reg(CFG_BOARD_SIZE, 5'd2);
    write_reg(CFG_INITIAL_WALLS, 5'd3);
    send_board(2, 1'b1, 1'b0);
    write_reg(CFG_INITIAL_WALLS, 5'd5);
    send_board(4, 1'b1, 1'b1);
    send_board(1, 1'b1, 1'b0);
    write_reg(stray_index(), CFG_DATA_W'($urandom));
    send_board(3, 1'b0, 1'b1);
  endtask

  // On the 16x16 board, fold every cell key, run past the end into counter
  // saturation, then check the counter restarts cleanly.
  task automatic test_counter_saturation();
    write_reg(CFG_BOARD_SIZE, 5'd16);
    write_reg(CFG_INITIAL_WALLS, CFG_DATA_W'($urandom_range(0, 31)));
    no_idle = 1'b1;
    send_board(CNT_MAX + 4, 1'b1, 1'b1);
    send_board(1, 1'b1, 1'b1);
    no_idle = 1'b0;
  endtask

  // Random configurations; mostly well-formed boards, some short or overlong ones.
  task automatic test_random_boards();
    int unsigned start, n, boards, cells, kind;
    logic [4:0]  dim;
    start = cells_sent;
    while (cells_sent - start < RANDOM_CELLS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 11))
        0:       dim = 5'd0;
        1:       dim = BOARD_SIZE_RST;
        default: dim = 5'($urandom_range(1, 5));
      endcase
      write_reg(CFG_BOARD_SIZE, dim);
      write_reg(CFG_INITIAL_WALLS, CFG_DATA_W'($urandom_range(0, 31)));
      if ($urandom_range(0, 5) == 0) write_reg(stray_index(), CFG_DATA_W'($urandom));
      n      = board_dim();
      boards = (n >= 9) ? 1 : $urandom_range(3, 8);
      repeat (boards) begin
        kind  = $urandom_range(0, 9);
        cells = n * n;
        if (kind == 8) cells = $urandom_range(1, n * n);
        else if (kind == 9) cells = n * n + $urandom_range(1, 3);
        send_board(cells, $urandom_range(0, 99) < 85, 1'b1);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    board_reg = BOARD_SIZE_RST;
    walls_reg = INITIAL_WALLS_RST;
    fill_key_tables();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_config();
    test_size_extremes();
    test_board_abandon();
    test_counter_saturation();
    test_random_boards();

    settle();
    if (mismatches == 0 && expected_hashes.size() == 0) begin
      $display("** zobrist_board_hash_top: PASSED **");
    end else begin
      $display("** zobrist_board_hash_top: FAILED **");
    end
    $finish;
  end

endmodule
